@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the rational arithmetic unit.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Consequent must hold in the same cycle as the antecedent.
`define RAU_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rau assertion failed");
// Consequent must hold in the cycle after the antecedent.
`define RAU_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rau assertion failed");
`endif

@@ rtl/rau_pkg.sv @@
// Package of the rational arithmetic unit: payload structs, operation codes,
// controller-to-datapath command and status structs. No dependencies.
`timescale 1ns / 1ps
package rau_pkg;
	localparam int FIELD_W   = 16;
	localparam int NUM_OUT_W = 33;
	localparam int DEN_OUT_W = 32;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		MSTEP_T1  = 2'd0,
		MSTEP_T2  = 2'd1,
		MSTEP_DEN = 2'd2
	} mstep_t;

	typedef struct packed {
		logic [1:0]                operation;
		logic signed [FIELD_W-1:0] a_numerator;
		logic signed [FIELD_W-1:0] a_denominator;
		logic signed [FIELD_W-1:0] b_numerator;
		logic signed [FIELD_W-1:0] b_denominator;
	} in_item_t;

	typedef struct packed {
		logic signed [NUM_OUT_W-1:0] result_numerator;
		logic signed [DEN_OUT_W-1:0] result_denominator;
		logic                        zero_denominator;
	} out_item_t;

	typedef struct packed {
		logic   load;
		logic   mul_en;
		mstep_t mul_sel;
		logic   sum;
		logic   gcd_step;
		logic   div_step;
		logic   div_den;
		logic   out_load;
	} cmd_t;

	typedef struct packed {
		logic den_zero;
		logic gcd_done;
		logic div_last;
	} sts_t;
endpackage

@@ rtl/rational_arithmetic_unit.sv @@
// Top level of the rational arithmetic unit: ties controller and datapath.
// Depends on rau_pkg, rau_ctrl, rau_dp.
`timescale 1ns / 1ps
//
// channel  | handshake            | payload
// ---------+----------------------+---------------------------------
// input    | in_valid / in_ready  | in_data  (op, two fractions)
// output   | out_valid / out_ready| out_data (reduced fraction, flag)
//
// A transaction runs through accept, three multiply steps, sum, the binary GCD
//   steps and two restoring divisions (numerator, then denominator), then the
//   output load.
// A zero denominator skips GCD and division.
// Reset clears controller state and output valid only.
// A result waiting on out_ready does not block the next input transaction.
module rational_arithmetic_unit #(
	parameter int OPERAND_WIDTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  rau_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output rau_pkg::out_item_t out_data
);
	import rau_pkg::*;

	// command and status between controller and datapath
	cmd_t cmd;
	sts_t sts;

	rau_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	rau_dp #(
		.OPERAND_WIDTH (OPERAND_WIDTH)
	) u_dp (
		.clk      (clk),
		.cmd      (cmd),
		.in_data  (in_data),
		.sts      (sts),
		.out_data (out_data)
	);
endmodule

@@ rtl/rau_dp.sv @@
// Datapath of the rational arithmetic unit: shared multiplier, sign-magnitude
// adder, binary GCD and restoring divider. Depends on rau_pkg.
`timescale 1ns / 1ps
module rau_dp #(
	parameter int OPERAND_WIDTH = 16
) (
	input  logic              clk,
	input  rau_pkg::cmd_t     cmd,
	input  rau_pkg::in_item_t in_data,
	output rau_pkg::sts_t     sts,
	output rau_pkg::out_item_t out_data
);
	import rau_pkg::*;

	localparam int W  = OPERAND_WIDTH;
	localparam int PW = 2 * W;
	localparam int NW = 2 * W + 1;
	localparam int CW = $clog2(NW + 1);
	localparam int EN = (NW > NUM_OUT_W) ? NW : NUM_OUT_W;
	localparam int ED = (PW > DEN_OUT_W) ? PW : DEN_OUT_W;

	function automatic logic [W:0] to_sm(input logic [FIELD_W-1:0] f);
		logic [31:0]  v32;
		logic [W-1:0] v;
		logic [W-1:0] m;
		v32 = 32'(f);
		v   = v32[W-1:0];
		m   = v[W-1] ? (~v + 1'b1) : v;
		return {v[W-1] && (m != '0), m};
	endfunction

	op_t          op_q;
	logic         sgn_q [4];
	logic [W-1:0] mag_q [4];
	logic         t1_neg_q, t2_neg_q, den_neg_q, num_neg_q;
	logic [PW-1:0] t1_q, t2_q, den_mag_q;
	logic [NW-1:0] num_mag_q;
	logic [NW-1:0] gx_q, gy_q, divisor_q, drem_q, dq_q;
	logic [CW-1:0] gk_q, dcnt_q;
	out_item_t     out_q;

	logic [W:0] sm_an, sm_ad, sm_bn, sm_bd;
	assign sm_an = to_sm(in_data.a_numerator);
	assign sm_ad = to_sm(in_data.a_denominator);
	assign sm_bn = to_sm(in_data.b_numerator);
	assign sm_bd = to_sm(in_data.b_denominator);

	// operand select for the shared multiplier: 0 an, 1 ad, 2 bn, 3 bd
	logic [W-1:0]  mx, my;
	logic          sx, sy;
	logic [PW-1:0] prod;
	logic          pneg;
	always_comb begin
		unique case (cmd.mul_sel)
			MSTEP_T1: begin
				mx = mag_q[0]; sx = sgn_q[0];
				my = (op_q == OP_MUL) ? mag_q[2] : mag_q[3];
				sy = (op_q == OP_MUL) ? sgn_q[2] : sgn_q[3];
			end
			MSTEP_T2: begin
				mx = mag_q[2]; sx = sgn_q[2];
				my = mag_q[1]; sy = sgn_q[1];
			end
			default: begin
				mx = mag_q[1]; sx = sgn_q[1];
				my = (op_q == OP_DIV) ? mag_q[2] : mag_q[3];
				sy = (op_q == OP_DIV) ? sgn_q[2] : sgn_q[3];
			end
		endcase
		prod = PW'(mx) * PW'(my);
		pneg = (prod != '0) && (sx ^ sy);
	end

	logic [NW-1:0] sa, sb, smag;
	logic          sneg;
	always_comb begin
		sa = NW'(t1_q);
		sb = NW'(t2_q);
		if (t1_neg_q == t2_neg_q) begin
			smag = sa + sb; sneg = t1_neg_q;
		end else if (sa >= sb) begin
			smag = sa - sb; sneg = t1_neg_q;
		end else begin
			smag = sb - sa; sneg = t2_neg_q;
		end
		if (smag == '0) sneg = 1'b0;
	end

	logic          gdone;
	logic [NW-1:0] gnow;
	assign gdone = (gx_q == '0) || (gy_q == '0);
	assign gnow  = (gx_q | gy_q) << gk_q;

	logic [NW:0]   rr, rnew;
	logic          ge;
	logic [NW-1:0] qnew;
	logic          dlast;
	always_comb begin
		rr   = {drem_q, dq_q[NW-1]};
		ge   = rr >= {1'b0, divisor_q};
		rnew = ge ? (rr - {1'b0, divisor_q}) : rr;
		qnew = {dq_q[NW-2:0], ge};
	end
	assign dlast = dcnt_q == CW'(NW - 1);

	logic [EN-1:0] nv, nenc;
	logic [ED-1:0] dv, denc;
	always_comb begin
		nv   = EN'(num_mag_q);
		nenc = num_neg_q ? (~nv + 1'b1) : nv;
		dv   = ED'(den_mag_q);
		denc = den_neg_q ? (~dv + 1'b1) : dv;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= op_t'(in_data.operation);
			sgn_q[0] <= sm_an[W]; mag_q[0] <= sm_an[W-1:0];
			sgn_q[1] <= sm_ad[W]; mag_q[1] <= sm_ad[W-1:0];
			sgn_q[2] <= sm_bn[W]; mag_q[2] <= sm_bn[W-1:0];
			sgn_q[3] <= sm_bd[W]; mag_q[3] <= sm_bd[W-1:0];
		end
		if (cmd.mul_en) begin
			unique case (cmd.mul_sel)
				MSTEP_T1: begin
					t1_q <= prod; t1_neg_q <= pneg;
				end
				MSTEP_T2: begin
					if (op_q == OP_ADD || op_q == OP_SUB) begin
						t2_q     <= prod;
						t2_neg_q <= (prod != '0) && (pneg ^ (op_q == OP_SUB));
					end else begin
						t2_q <= '0; t2_neg_q <= 1'b0;
					end
				end
				default: begin
					den_mag_q <= prod; den_neg_q <= pneg;
				end
			endcase
		end
		if (cmd.sum) begin
			num_mag_q <= smag; num_neg_q <= sneg;
			gx_q <= smag; gy_q <= NW'(den_mag_q); gk_q <= '0;
		end
		if (cmd.gcd_step) begin
			if (gdone) begin
				divisor_q <= gnow; drem_q <= '0; dq_q <= num_mag_q; dcnt_q <= '0;
			end else if (!gx_q[0] && !gy_q[0]) begin
				gx_q <= gx_q >> 1; gy_q <= gy_q >> 1; gk_q <= gk_q + 1'b1;
			end else if (!gx_q[0]) begin
				gx_q <= gx_q >> 1;
			end else if (!gy_q[0]) begin
				gy_q <= gy_q >> 1;
			end else if (gx_q >= gy_q) begin
				gx_q <= (gx_q - gy_q) >> 1;
			end else begin
				gy_q <= (gy_q - gx_q) >> 1;
			end
		end
		if (cmd.div_step) begin
			if (dlast && !cmd.div_den) begin
				// numerator done: keep its quotient, restart on the denominator
				num_mag_q <= qnew;
				dq_q <= NW'(den_mag_q); drem_q <= '0; dcnt_q <= '0;
			end else begin
				drem_q <= rnew[NW-1:0];
				dq_q   <= qnew;
				dcnt_q <= dcnt_q + 1'b1;
				if (dlast) den_mag_q <= qnew[PW-1:0];
			end
		end
		if (cmd.out_load) begin
			out_q.result_numerator   <= nenc[NUM_OUT_W-1:0];
			out_q.result_denominator <= denc[DEN_OUT_W-1:0];
			out_q.zero_denominator   <= den_mag_q == '0;
		end
	end

	assign sts.den_zero = den_mag_q == '0;
	assign sts.gcd_done = gdone;
	assign sts.div_last = dlast;
	assign out_data     = out_q;
endmodule

@@ rtl/rau_ctrl.sv @@
// Controller of the rational arithmetic unit: sequences multiply, sum, GCD
// and the two divisions, and owns the handshakes. Depends on rau_pkg.
`timescale 1ns / 1ps
module rau_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  rau_pkg::sts_t sts,
	output rau_pkg::cmd_t cmd
);
	import rau_pkg::*;
	`include "assert_macros.svh"

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_MUL  = 7'b0000010,
		S_SUM  = 7'b0000100,
		S_GCD  = 7'b0001000,
		S_DIVN = 7'b0010000,
		S_DIVD = 7'b0100000,
		S_DONE = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	mstep_t mstep_q, mstep_d;
	logic   out_valid_q;

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d     = state_q;
		mstep_d     = mstep_q;
		cmd         = '0;
		cmd.mul_sel = mstep_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1; state_d = S_MUL; mstep_d = MSTEP_T1;
				end
			end
			S_MUL: begin
				cmd.mul_en = 1'b1;
				unique case (mstep_q)
					MSTEP_T1: mstep_d = MSTEP_T2;
					MSTEP_T2: mstep_d = MSTEP_DEN;
					default:  state_d = S_SUM;
				endcase
			end
			S_SUM: begin
				cmd.sum = 1'b1;
				state_d = sts.den_zero ? S_DONE : S_GCD;
			end
			S_GCD: begin
				cmd.gcd_step = 1'b1;
				if (sts.gcd_done) state_d = S_DIVN;
			end
			S_DIVN: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) state_d = S_DIVD;
			end
			S_DIVD: begin
				cmd.div_step = 1'b1; cmd.div_den = 1'b1;
				if (sts.div_last) state_d = S_DONE;
			end
			default: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1; state_d = S_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mstep_q     <= MSTEP_T1;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			mstep_q <= mstep_d;
			if (cmd.out_load)   out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	`RAU_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, !in_ready)
	`RAU_ASSERT_NOW(a_gcd_nonzero_den, cmd.gcd_step, !sts.den_zero)
	`RAU_ASSERT_NEXT(a_load_shows, cmd.out_load, out_valid)
endmodule

@@ bench/tb_rational_arithmetic_unit.sv @@
// Self-checking bench for rational_arithmetic_unit: directed and random fractions,
// random idling on both channels, results compared with a built-in predictor.
// Depends on rau_pkg and the RTL of rational_arithmetic_unit.
`timescale 1ns / 1ps
module tb_rational_arithmetic_unit;
	import rau_pkg::*;

	localparam int CLK_PERIOD = 12;
	localparam int TAIL_CYCLES = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;

	out_item_t expected_fractions[$];
	int error_count = 0;
	bit no_idle = 1'b0;

	rational_arithmetic_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Sign-magnitude helpers at 64 bits: every product of 16-bit operands is exact.
	typedef struct {
		bit neg;
		longint unsigned mag;
	} signmag_t;

	function automatic signmag_t split_sign(logic signed [FIELD_W-1:0] v);
		signmag_t r;
		longint signed wide;
		wide = v;
		r.neg = v[FIELD_W-1];
		r.mag = r.neg ? longint'(-wide) : longint'(wide);
		if (r.mag == 0)
			r.neg = 1'b0;
		return r;
	endfunction

	function automatic signmag_t sm_product(signmag_t x, signmag_t y);
		signmag_t r;
		r.mag = x.mag * y.mag;
		r.neg = (r.mag != 0) && (x.neg != y.neg);
		return r;
	endfunction

	function automatic signmag_t sm_sum(signmag_t x, signmag_t y);
		signmag_t r;
		if (x.neg == y.neg) begin
			r.mag = x.mag + y.mag;
			r.neg = x.neg;
		end else if (x.mag >= y.mag) begin
			r.mag = x.mag - y.mag;
			r.neg = x.neg;
		end else begin
			r.mag = y.mag - x.mag;
			r.neg = y.neg;
		end
		if (r.mag == 0)
			r.neg = 1'b0;
		return r;
	endfunction

	// Compute the reduced fraction the block must return for one transaction.
	function automatic out_item_t reduce_fraction(in_item_t item);
		out_item_t r;
		signmag_t an, ad, bn, bd, num, den, t;
		longint unsigned x, y, rem;
		longint unsigned enc_num, enc_den;
		an = split_sign(item.a_numerator);
		ad = split_sign(item.a_denominator);
		bn = split_sign(item.b_numerator);
		bd = split_sign(item.b_denominator);
		case (op_t'(item.operation))
			OP_ADD: begin
				num = sm_sum(sm_product(an, bd), sm_product(bn, ad));
				den = sm_product(ad, bd);
			end
			OP_SUB: begin
				t = sm_product(bn, ad);
				if (t.mag != 0)
					t.neg = !t.neg;
				num = sm_sum(sm_product(an, bd), t);
				den = sm_product(ad, bd);
			end
			OP_MUL: begin
				num = sm_product(an, bn);
				den = sm_product(ad, bd);
			end
			default: begin
				num = sm_product(an, bd);
				den = sm_product(ad, bn);
			end
		endcase
		r.zero_denominator = (den.mag == 0);
		if (!r.zero_denominator) begin
			x = num.mag;
			y = den.mag;
			while (y != 0) begin
				rem = x % y;
				x = y;
				y = rem;
			end
			if (x != 0) begin
				num.mag = num.mag / x;
				den.mag = den.mag / x;
			end
		end
		enc_num = num.neg ? (64'd0 - num.mag) : num.mag;
		enc_den = den.neg ? (64'd0 - den.mag) : den.mag;
		r.result_numerator = enc_num[NUM_OUT_W-1:0];
		r.result_denominator = enc_den[DEN_OUT_W-1:0];
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		error_count++;
	endtask

	function automatic int draw_wait();
		return no_idle ? 0 : $urandom_range(0, 14);
	endfunction

	// Send one transaction; the expectation is queued at the accepting edge.
	task automatic send_fraction_pair(in_item_t item);
		int gap;
		gap = draw_wait();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_data <= item;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		expected_fractions.push_back(reduce_fraction(item));
	endtask

	task automatic send_fields(op_t op, logic signed [15:0] an, logic signed [15:0] ad,
			logic signed [15:0] bn, logic signed [15:0] bd);
		in_item_t item;
		item.operation = op;
		item.a_numerator = an;
		item.a_denominator = ad;
		item.b_numerator = bn;
		item.b_denominator = bd;
		send_fraction_pair(item);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_fractions.size() != 0) @(posedge clk);
	endtask

	// Drive out_ready: stall a random number of cycles before each result.
	initial begin
		int stall;
		forever begin
			stall = draw_wait();
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Compare every accepted result with the oldest expectation.
	always @(posedge clk) begin
		out_item_t exp_item;
		if (arst_n && out_valid && out_ready) begin
			if (expected_fractions.size() == 0) begin
				report_mismatch("result with no transaction outstanding");
			end else begin
				exp_item = expected_fractions.pop_front();
				if (out_data.result_numerator !== exp_item.result_numerator)
					report_mismatch($sformatf("numerator got %0d exp %0d",
						out_data.result_numerator, exp_item.result_numerator));
				if (out_data.result_denominator !== exp_item.result_denominator)
					report_mismatch($sformatf("denominator got %0d exp %0d",
						out_data.result_denominator, exp_item.result_denominator));
				if (out_data.zero_denominator !== exp_item.zero_denominator)
					report_mismatch($sformatf("zero flag got %0b exp %0b",
						out_data.zero_denominator, exp_item.zero_denominator));
			end
		end
	end

	task automatic test_extremes();
		send_fields(OP_ADD, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
		send_fields(OP_SUB, -16'sd32768, 16'sh7fff, 16'sh7fff, -16'sd32768);
		send_fields(OP_MUL, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
		send_fields(OP_DIV, -16'sd32768, 16'sd1, 16'sd1, -16'sd32768);
		send_fields(OP_ADD, -16'sd32768, 16'sd1, -16'sd32768, 16'sd1);
		send_fields(OP_MUL, 16'sh7fff, -16'sd1, -16'sd32768, 16'sd1);
		send_fields(OP_DIV, 16'sh7fff, -16'sd32768, -16'sd32768, 16'sh7fff);
	endtask

	task automatic test_operations();
		send_fields(OP_ADD, 16'sd1, 16'sd2, 16'sd1, 16'sd3);
		send_fields(OP_SUB, 16'sd3, 16'sd4, 16'sd1, 16'sd4);
		send_fields(OP_MUL, -16'sd6, 16'sd10, 16'sd5, 16'sd9);
		send_fields(OP_DIV, 16'sd4, -16'sd6, 16'sd2, 16'sd3);
		send_fields(OP_SUB, 16'sd1, 16'sd2, 16'sd2, 16'sd4);
	endtask

	task automatic test_special_cases();
		// zero numerator, both signs of denominator
		send_fields(OP_MUL, 16'sd0, 16'sd5, 16'sd3, 16'sd7);
		send_fields(OP_MUL, 16'sd0, -16'sd5, 16'sd3, 16'sd7);
		send_fields(OP_SUB, 16'sd2, -16'sd3, 16'sd2, -16'sd3);
		// zero denominator, left unreduced
		send_fields(OP_ADD, 16'sd4, 16'sd0, 16'sd6, 16'sd2);
		send_fields(OP_DIV, 16'sd4, 16'sd2, 16'sd0, 16'sd3);
		send_fields(OP_MUL, -16'sd8, 16'sd6, 16'sd2, 16'sd0);
		// both zero
		send_fields(OP_DIV, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
		send_fields(OP_ADD, 16'sd0, 16'sd0, 16'sd5, 16'sd0);
		// negative denominator operands, result signs kept as computed
		send_fields(OP_ADD, 16'sd1, -16'sd2, 16'sd1, 16'sd2);
		send_fields(OP_MUL, 16'sd9, -16'sd12, -16'sd4, -16'sd3);
	endtask

	function automatic logic signed [15:0] pick_operand();
		case ($urandom_range(0, 9))
			0: return 16'sd0;
			1, 2: return 16'($signed($urandom_range(0, 40)) - 20);
			3: return ($urandom_range(0, 1) != 0) ? 16'sh7fff : -16'sd32768;
			4: return 16'($signed($urandom_range(0, 2000)) - 1000);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic test_random(int count);
		in_item_t item;
		for (int i = 0; i < count; i++) begin
			// stretches of 100 items, each with or without idling at random
			if (i % 100 == 0)
				no_idle = ($urandom_range(0, 3) == 0);
			if (i == count / 2) begin
				// hold off until the block has returned everything
				drain_results();
			end
			item.operation = 2'($urandom_range(0, 3));
			item.a_numerator = pick_operand();
			item.a_denominator = pick_operand();
			item.b_numerator = pick_operand();
			item.b_denominator = pick_operand();
			send_fraction_pair(item);
		end
		no_idle = 1'b0;
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_operations();
		test_special_cases();
		test_random(800);
		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0 && expected_fractions.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#(CLK_PERIOD * 2000000);
		$display("CHECKS FAILED");
		$finish;
	end
endmodule

@@ filelist.f @@
+incdir+rtl
rtl/rau_pkg.sv
rtl/rau_dp.sv
rtl/rau_ctrl.sv
rtl/rational_arithmetic_unit.sv
bench/tb_rational_arithmetic_unit.sv
